[hw/rtl/running_median_tracker_core_assert.svh]
// assertion helpers used by the checker file rmt_checker
`ifndef RUNNING_MEDIAN_TRACKER_CORE_ASSERT_SVH
`define RUNNING_MEDIAN_TRACKER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmt check failed");

// next-cycle implication, checked outside reset
`define RMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmt check failed");

`endif

[hw/rtl/rmt_pkg.sv]
package rmt_pkg;

    localparam int CAPACITY     = 1024;
    localparam int SAMPLE_WIDTH = 32;

    // both halves use chains of the larger half's depth
    localparam int CHAIN_DEPTH = (CAPACITY + 1) / 2;
    localparam int CNT_W       = $clog2(CHAIN_DEPTH + 1);
    localparam int COUNT_W     = $clog2(CAPACITY + 1);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [SAMPLE_WIDTH-1:0]        key_t;
    typedef logic [CNT_W-1:0]               half_cnt_t;
    typedef logic [COUNT_W-1:0]             count_t;
    typedef logic [1:0]                     op_t;

    localparam key_t KEY_BIAS = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // chain operations
    localparam op_t OP_NOP     = 2'd0;
    localparam op_t OP_INS     = 2'd1;   // sorted insert of x
    localparam op_t OP_POP_INS = 2'd2;   // drop front, sorted insert of x (x not below front)

    typedef struct packed {
        op_t  op;
        key_t x;
    } chain_cmd_t;

    typedef struct packed {
        key_t key;
        logic valid;
    } chain_head_t;

endpackage

[hw/rtl/rmt_cell.sv]
module rmt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  rmt_pkg::chain_cmd_t cmd,
    input  rmt_pkg::key_t      left_key,
    input  logic               left_le,
    input  logic               left_valid,
    input  rmt_pkg::key_t      right_key,
    input  logic               right_le,
    output rmt_pkg::key_t      key,
    output logic               le,
    output logic               valid
);
    import rmt_pkg::*;

    key_t key_reg;
    key_t key_next;
    logic valid_reg;
    logic valid_next;

    // held entry sorts at or before the incoming key
    assign le    = valid_reg && (key_reg <= cmd.x);
    assign key   = key_reg;
    assign valid = valid_reg;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        case (cmd.op)
            OP_INS:
            begin
                if (!le)
                begin
                    key_next = left_le ? cmd.x : left_key;
                end
                valid_next = valid_reg | left_valid;
            end
            OP_POP_INS:
            begin
                if (right_le)
                begin
                    key_next = right_key;
                end
                else if (le)
                begin
                    key_next = cmd.x;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

[hw/rtl/rmt_chain.sv]
module rmt_chain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rmt_pkg::chain_cmd_t  cmd,
    output rmt_pkg::chain_head_t head
);
    import rmt_pkg::*;

    key_t key_w   [CHAIN_DEPTH];
    logic le_w    [CHAIN_DEPTH];
    logic valid_w [CHAIN_DEPTH];

    for (genvar i = 0; i < CHAIN_DEPTH; i++)
    begin : g_cell
        key_t lk;
        key_t rk;
        logic ll;
        logic lv;
        logic rl;

        // front cell sees an always-smaller, always-valid neighbor
        if (i == 0)
        begin : g_first
            assign lk = '0;
            assign ll = 1'b1;
            assign lv = 1'b1;
        end
        else
        begin : g_mid_l
            assign lk = key_w[i-1];
            assign ll = le_w[i-1];
            assign lv = valid_w[i-1];
        end

        if (i == CHAIN_DEPTH - 1)
        begin : g_last
            assign rk = '0;
            assign rl = 1'b0;
        end
        else
        begin : g_mid_r
            assign rk = key_w[i+1];
            assign rl = le_w[i+1];
        end

        rmt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_key   (lk),
            .left_le    (ll),
            .left_valid (lv),
            .right_key  (rk),
            .right_le   (rl),
            .key        (key_w[i]),
            .le         (le_w[i]),
            .valid      (valid_w[i])
        );
    end

    assign head.key   = key_w[0];
    assign head.valid = valid_w[0];

endmodule

[hw/rtl/running_median_tracker_core.sv]
// running median of a signed sample stream
// sample channel: sample_valid / sample_stall carry one signed sample per request
// result channel: result_valid / result_stall carry lower_median, upper_median,
//   sample_count, count_even and sample_dropped, one result per accepted sample
// the samples live in two chains of sorted cells: the lower half (stored inverted,
//   so its largest value sits in the front cell) and the upper half (smallest in front)
// each request runs decide -> apply -> report; the one-request-at-a-time sequencer
//   around the cell chains takes no new sample until the last result is written
// a finished result waits in the output register while the next sample is taken;
//   if the receiver stalls, the sequencer holds in report until the register frees
// reset empties both chains at once (cell valid bits) and clears the half counts
// once the store is full, samples are dropped and flagged with the last medians
module running_median_tracker_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  rmt_pkg::sample_t sample,
    output logic             result_valid,
    input  logic             result_stall,
    output rmt_pkg::sample_t lower_median,
    output rmt_pkg::sample_t upper_median,
    output rmt_pkg::count_t  sample_count,
    output logic             count_even,
    output logic             sample_dropped
);
    import rmt_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECIDE = 2'd1;
    localparam logic [1:0] ST_APPLY  = 2'd2;
    localparam logic [1:0] ST_REPORT = 2'd3;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    key_t        key_reg;
    key_t        key_next;
    chain_cmd_t  cmd_lo_reg;
    chain_cmd_t  cmd_lo_next;
    chain_cmd_t  cmd_up_reg;
    chain_cmd_t  cmd_up_next;
    half_cnt_t   lo_cnt_reg;
    half_cnt_t   lo_cnt_next;
    half_cnt_t   up_cnt_reg;
    half_cnt_t   up_cnt_next;
    logic        drop_reg;
    logic        drop_next;

    logic        result_valid_reg;
    logic        result_valid_next;
    sample_t     lower_reg;
    sample_t     lower_next;
    sample_t     upper_reg;
    sample_t     upper_next;
    count_t      count_reg;
    count_t      count_next;
    logic        dropped_reg;
    logic        dropped_next;

    chain_head_t lo_head;
    chain_head_t up_head;
    count_t      total;
    key_t        lo_max;
    logic        accept;
    logic        out_free;

    // lower half keeps inverted keys so its maximum is at the front
    rmt_chain u_lower (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_lo_reg),
        .head  (lo_head)
    );

    rmt_chain u_upper (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_up_reg),
        .head  (up_head)
    );

    assign total    = count_t'(lo_cnt_reg) + count_t'(up_cnt_reg);
    assign lo_max   = ~lo_head.key;
    assign accept   = sample_valid && !sample_stall;
    assign out_free = !result_valid_reg || !result_stall;

    assign sample_stall   = (state_reg != ST_IDLE);
    assign result_valid   = result_valid_reg;
    assign lower_median   = lower_reg;
    assign upper_median   = upper_reg;
    assign sample_count   = count_reg;
    assign count_even     = ~count_reg[0];
    assign sample_dropped = dropped_reg;

    always_comb
    begin
        state_next        = state_reg;
        key_next          = key_reg;
        cmd_lo_next       = '{op: OP_NOP, x: key_reg};
        cmd_up_next       = '{op: OP_NOP, x: key_reg};
        lo_cnt_next       = lo_cnt_reg;
        up_cnt_next       = up_cnt_reg;
        drop_next         = drop_reg;
        result_valid_next = result_valid_reg && result_stall;
        lower_next        = lower_reg;
        upper_next        = upper_reg;
        count_next        = count_reg;
        dropped_next      = dropped_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // sign-biased key: unsigned order equals signed order
                    key_next   = key_t'(sample) ^ KEY_BIAS;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                drop_next = (total == count_t'(CAPACITY));
                if (total == count_t'(CAPACITY))
                begin
                    // store full, nothing moves
                end
                else if (lo_cnt_reg == up_cnt_reg)
                begin
                    // lower half grows
                    lo_cnt_next = lo_cnt_reg + half_cnt_t'(1);
                    if (!up_head.valid || key_reg <= up_head.key)
                    begin
                        cmd_lo_next = '{op: OP_INS, x: ~key_reg};
                    end
                    else
                    begin
                        // upper front moves down, new key takes its place
                        cmd_lo_next = '{op: OP_INS, x: ~up_head.key};
                        cmd_up_next = '{op: OP_POP_INS, x: key_reg};
                    end
                end
                else
                begin
                    // upper half grows
                    up_cnt_next = up_cnt_reg + half_cnt_t'(1);
                    if (key_reg >= lo_max)
                    begin
                        cmd_up_next = '{op: OP_INS, x: key_reg};
                    end
                    else
                    begin
                        // lower maximum moves up, new key takes its place
                        cmd_up_next = '{op: OP_INS, x: lo_max};
                        cmd_lo_next = '{op: OP_POP_INS, x: ~key_reg};
                    end
                end
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                // chains shift this cycle
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    lower_next        = lo_head.valid ? sample_t'(lo_max ^ KEY_BIAS) : '0;
                    if (!total[0] && up_head.valid)
                    begin
                        upper_next = sample_t'(up_head.key ^ KEY_BIAS);
                    end
                    else
                    begin
                        upper_next = lower_next;
                    end
                    count_next   = total;
                    dropped_next = drop_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cmd_lo_reg       <= '{op: OP_NOP, x: '0};
            cmd_up_reg       <= '{op: OP_NOP, x: '0};
            lo_cnt_reg       <= '0;
            up_cnt_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cmd_lo_reg       <= cmd_lo_next;
            cmd_up_reg       <= cmd_up_next;
            lo_cnt_reg       <= lo_cnt_next;
            up_cnt_reg       <= up_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        drop_reg    <= drop_next;
        lower_reg   <= lower_next;
        upper_reg   <= upper_next;
        count_reg   <= count_next;
        dropped_reg <= dropped_next;
    end

endmodule

[hw/rtl/rmt_checker.sv]
module rmt_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_stall,
    input logic             result_valid,
    input logic             result_stall,
    input rmt_pkg::sample_t lower_median,
    input rmt_pkg::sample_t upper_median,
    input rmt_pkg::count_t  sample_count,
    input logic             count_even,
    input logic             sample_dropped
);
    import rmt_pkg::*;

`include "running_median_tracker_core_assert.svh"

    // one request in flight: the sample side closes right after a take
    `RMT_ASSERT_NXT(a_one_in_flight, clk, rst_n, sample_valid && !sample_stall, sample_stall)

    // medians stay ordered
    `RMT_ASSERT_IMP(a_median_order, clk, rst_n, result_valid, lower_median <= upper_median)

    // a dropped sample only happens on a full store, and parity matches the count
    `RMT_ASSERT_IMP(a_drop_full, clk, rst_n, result_valid && sample_dropped,
        sample_count == count_t'(CAPACITY) && count_even)

    // a stalled result holds
    `RMT_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && result_stall,
        result_valid && $stable(lower_median) && $stable(upper_median))

endmodule

bind running_median_tracker_core rmt_checker u_rmt_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 100ps

// running median tracker: directed corner cases, a back-to-back burst and a long
// random stream that fills the store and runs past capacity into dropped samples
module tb_top;
    import rmt_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    // hang guard, well above the slowest correct run of roughly 1050 requests
    localparam int CYCLE_LIMIT  = 200000;
    // extra wait after the final drain, to watch for stray results
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_WAIT     = 4;
    localparam int BURST_ITEMS  = 100;
    localparam int RANDOM_ITEMS = 927;
    localparam int PRINT_CAP    = 100;

    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    // one expected result: both middle values, the held count and the flags
    typedef struct packed {
        sample_t lower;
        sample_t upper;
        count_t  held;
        logic    even;
        logic    dropped;
    } median_report_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    sample_valid = 1'b0;
    logic    sample_stall;
    sample_t sample       = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    sample_t lower_median;
    sample_t upper_median;
    count_t  sample_count;
    logic    count_even;
    logic    sample_dropped;

    // every sample held so far, kept in ascending order
    sample_t        held_sorted[$];
    // expected results in request order
    median_report_t pending_medians[$];

    sample_t     last_value     = '0;
    bit          no_idle        = 1'b0;
    int unsigned stall_left     = 0;
    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned samples_pushed = 0;
    int unsigned results_seen   = 0;
    int unsigned drops_seen     = 0;

    running_median_tracker_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .lower_median   (lower_median),
        .upper_median   (upper_median),
        .sample_count   (sample_count),
        .count_even     (count_even),
        .sample_dropped (sample_dropped)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // hard stop if the handshakes ever lock up
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // idle cycles before a request or stall cycles on a result, none during bursts
    function automatic int unsigned draw_wait();
        if (no_idle)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // add one sample to the multiset and queue the result it should produce
    // lower middle is index (n-1)/2 of the sorted set, upper middle is index n/2;
    // for an odd count those are the same element
    function automatic void insert_and_take_medians(input sample_t value);
        median_report_t want;
        int             pos;
        int             n;
        want.dropped = 1'b0;
        if (held_sorted.size() >= CAPACITY)
        begin
            // store full: sample ignored, last medians repeated
            want.dropped = 1'b1;
        end
        else
        begin
            pos = 0;
            while (pos < held_sorted.size() && held_sorted[pos] <= value)
                pos++;
            held_sorted.insert(pos, value);
        end
        n          = held_sorted.size();
        want.lower = held_sorted[(n - 1) / 2];
        want.upper = held_sorted[n / 2];
        want.held  = count_t'(n);
        want.even  = (n % 2 == 0);
        pending_medians = {pending_medians, want};
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        // keep the log short when something is badly broken
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch on %s at result %0d: got %0d, want %0d",
                     what, results_seen, got, want);
    endtask

    task automatic check_result();
        median_report_t want;
        if (pending_medians.size() == 0)
        begin
            flag_mismatch("result with no request pending", lower_median, 0);
        end
        else
        begin
            want = pending_medians.pop_front();
            if (lower_median !== want.lower)
                flag_mismatch("lower_median", lower_median, want.lower);
            if (upper_median !== want.upper)
                flag_mismatch("upper_median", upper_median, want.upper);
            if (sample_count !== want.held)
                flag_mismatch("sample_count", sample_count, want.held);
            if (count_even !== want.even)
                flag_mismatch("count_even", count_even, want.even);
            if (sample_dropped !== want.dropped)
                flag_mismatch("sample_dropped", sample_dropped, want.dropped);
            if (want.dropped)
                drops_seen++;
        end
        results_seen++;
    endtask

    // result side: a stall count is drawn for the next result as soon as one is taken,
    // so stall may already be up when the next result lands, and it then waits in the register
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                check_result();
                stall_left = draw_wait();
            end
            else if (result_valid && stall_left > 0)
            begin
                stall_left = stall_left - 1;
            end
            result_stall <= (stall_left > 0);
        end
    end

    // send one request; valid stays high afterwards so a zero gap gives back-to-back
    // requests, and a nonzero gap lowers it first
    task automatic push_sample(input sample_t value);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        do
        begin
            @(posedge clk);
        end
        while (!(sample_valid && !sample_stall));
        insert_and_take_medians(value);
        samples_pushed++;
        last_value = value;
    endtask

    // drop valid and hold off until every outstanding result has come back
    task automatic pause_until_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_medians.size() != 0)
            @(posedge clk);
    endtask

    // half full-range values, plus small values and repeats for ties,
    // and values hugging the signed extremes
    function automatic sample_t random_sample();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return sample_t'($urandom);
        if (pick < 7)
            return sample_t'(int'($urandom_range(0, 16)) - 8);
        if (pick == 7)
        begin
            if ($urandom_range(0, 1) != 0)
                return sample_t'(SAMPLE_MIN + $urandom_range(0, 3));
            return sample_t'(SAMPLE_MAX - $urandom_range(0, 3));
        end
        return last_value;
    endfunction

    // signed extremes, zero and its neighbors, alternating bit patterns
    task automatic test_extreme_values();
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MAX);
        push_sample(sample_t'(0));
        push_sample(sample_t'(-1));
        push_sample(sample_t'(1));
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MAX);
        push_sample(sample_t'(32'h5555_5555));
        push_sample(sample_t'(32'hAAAA_AAAA));
    endtask

    // repeated values on both sides of the current middle
    task automatic test_equal_values();
        push_sample(sample_t'(7));
        push_sample(sample_t'(7));
        push_sample(sample_t'(-7));
        push_sample(sample_t'(7));
        push_sample(sample_t'(-7));
        push_sample(sample_t'(7));
    endtask

    // a rising run pulls the upper front down into the lower half,
    // a falling run pushes the lower top up into the upper half
    task automatic test_sorted_runs();
        int k;
        for (k = 1; k <= 4; k++)
            push_sample(sample_t'(k * 100));
        for (k = 1; k <= 4; k++)
            push_sample(sample_t'(-k * 100));
    endtask

    // full rate on both sides
    task automatic test_back_to_back();
        int k;
        no_idle = 1'b1;
        for (k = 0; k < BURST_ITEMS; k++)
            push_sample(random_sample());
        no_idle = 1'b0;
    endtask

    // long stream that fills the store and keeps going so the tail is dropped;
    // every fourth stretch of 64 requests runs with no idling at all
    task automatic test_random_stream();
        int k;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            no_idle = ((k / 64) % 4 == 3);
            if (k == RANDOM_ITEMS / 2)
                pause_until_drained();
            push_sample(random_sample());
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_values();
        test_equal_values();
        test_sorted_runs();
        // sender waits for a fully empty pipeline before the burst
        pause_until_drained();
        test_back_to_back();
        test_random_stream();

        // let every outstanding result come back, then watch for strays
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d samples sent, %0d results compared",
                 samples_pushed, results_seen);
        $display("tb_top: store reached %0d samples, %0d later samples turned away",
                 held_sorted.size(), drops_seen);
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

[running_median_tracker_core.f]
+incdir+hw/rtl
hw/rtl/rmt_pkg.sv
hw/rtl/rmt_cell.sv
hw/rtl/rmt_chain.sv
hw/rtl/running_median_tracker_core.sv
hw/rtl/rmt_checker.sv
verif/tb_top.sv
